/* design/sfr_pkg.sv */
package sfr_pkg;

    localparam int MAX_PATTERN_BYTES = 8;
    localparam int CNT_W    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W    = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int PAT_W    = 8 * MAX_PATTERN_BYTES;
    localparam int TOTAL_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FIND_PATTERN    = 2'd0;
    localparam cfg_idx_t CFG_FIND_LENGTH     = 2'd1;
    localparam cfg_idx_t CFG_REPLACE_PATTERN = 2'd2;
    localparam cfg_idx_t CFG_REPLACE_LENGTH  = 2'd3;

    // One queued burst: up to MAX_PATTERN_BYTES output bytes, lowest octet first.
    typedef struct packed {
        logic [PAT_W-1:0]   bytes;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } cmd_t;

endpackage

/* design/sfr_front.sv */
module sfr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  sfr_pkg::cfg_idx_t    cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 cmd_push,
    output sfr_pkg::cmd_t        cmd
);
    import sfr_pkg::*;

    logic [PAT_W-1:0]   find_pat_reg;
    logic [3:0]         find_len_reg;
    logic [PAT_W-1:0]   repl_pat_reg;
    logic [3:0]         repl_len_reg;

    logic [7:0]         win_reg [MAX_PATTERN_BYTES];
    logic [7:0]         win_next [MAX_PATTERN_BYTES];
    logic [7:0]         win_new [MAX_PATTERN_BYTES];
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [TOTAL_W-1:0] match_cnt_reg;
    logic [TOTAL_W-1:0] match_cnt_next;

    logic [CNT_W-1:0]   fl;
    logic [CNT_W-1:0]   rl;
    logic [CNT_W-1:0]   c0;
    logic [CNT_W-1:0]   n1;
    logic               win_full;
    logic               hit;
    logic [TOTAL_W-1:0] match_inc;

    always_comb
    begin
        if (find_len_reg == 4'd0)
            fl = CNT_W'(1);
        else if (find_len_reg > 4'(MAX_PATTERN_BYTES))
            fl = CNT_W'(MAX_PATTERN_BYTES);
        else
            fl = CNT_W'(find_len_reg);

        if (repl_len_reg > 4'(MAX_PATTERN_BYTES))
            rl = CNT_W'(MAX_PATTERN_BYTES);
        else
            rl = CNT_W'(repl_len_reg);
    end

    // Place the new byte after the pending ones and compare the window.
    always_comb
    begin
        c0 = (cnt_reg >= fl) ? '0 : cnt_reg;
        n1 = c0 + CNT_W'(1);
        win_full = (n1 == fl);
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            win_new[i] = (IDX_W'(i) == c0[IDX_W-1:0]) ? in_byte : win_reg[i];
            if ((CNT_W'(i) < fl) && (win_new[i] != find_pat_reg[8*i +: 8]))
                hit = 1'b0;
        end
        match_inc = (match_cnt_reg == '1) ? match_cnt_reg : match_cnt_reg + TOTAL_W'(1);
    end

    always_comb
    begin
        cmd.last  = in_last;
        cmd.total = (win_full && hit) ? match_inc : match_cnt_reg;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            cmd.bytes[8*i +: 8] = win_new[i];
        cnt_next       = cnt_reg;
        match_cnt_next = match_cnt_reg;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            win_next[i] = win_reg[i];

        if (win_full && hit)
        begin
            cmd.bytes      = repl_pat_reg;
            cmd.count      = rl;
            cnt_next       = '0;
            match_cnt_next = match_inc;
        end
        else if (in_last)
        begin
            // flush everything still pending, oldest first
            cmd.count = n1;
            cnt_next  = n1;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                win_next[i] = win_new[i];
        end
        else if (win_full)
        begin
            cmd.count = CNT_W'(1);
            cnt_next  = fl - CNT_W'(1);
            for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++)
                win_next[i] = win_new[i + 1];
            win_next[MAX_PATTERN_BYTES - 1] = win_new[MAX_PATTERN_BYTES - 1];
        end
        else
        begin
            cmd.count = '0;
            cnt_next  = n1;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                win_next[i] = win_new[i];
        end

        if (in_last)
        begin
            cnt_next       = '0;
            match_cnt_next = '0;
        end
    end

    assign cmd_push = accept && ((cmd.count != '0) || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pat_reg  <= '0;
            find_len_reg  <= 4'd1;
            repl_pat_reg  <= '0;
            repl_len_reg  <= 4'd0;
            cnt_reg       <= '0;
            match_cnt_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIND_PATTERN:    find_pat_reg <= cfg_data[PAT_W-1:0];
                CFG_FIND_LENGTH:
                begin
                    find_len_reg <= cfg_data[3:0];
                    cnt_reg      <= '0;
                end
                CFG_REPLACE_PATTERN: repl_pat_reg <= cfg_data[PAT_W-1:0];
                CFG_REPLACE_LENGTH:  repl_len_reg <= cfg_data[3:0];
                default:             ;
            endcase
        end
        else if (accept)
        begin
            cnt_reg       <= cnt_next;
            match_cnt_reg <= match_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_valid)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

/* design/sfr_cmd_queue.sv */
module sfr_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sfr_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd_en,
    output sfr_pkg::cmd_t rd_cmd,
    output logic          empty
);
    import sfr_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign full   = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

/* design/sfr_back.sv */
module sfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sfr_pkg::cmd_t q_cmd,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic          out_byte_valid,
    output logic          out_last,
    output logic [15:0]   match_total
);
    import sfr_pkg::*;

    cmd_t             cur_reg;
    logic             cur_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             final_beat;
    logic             beat_done;

    assign empty          = !cur_valid_reg;
    assign out_byte_valid = (cur_reg.count != '0);
    assign final_beat     = !out_byte_valid
                            || ((CNT_W'(idx_reg) + CNT_W'(1)) == cur_reg.count);
    assign out_byte       = out_byte_valid ? cur_reg.bytes[8*idx_reg +: 8] : 8'd0;
    assign out_last       = cur_reg.last && final_beat;
    assign match_total    = out_last ? cur_reg.total : 16'd0;

    assign beat_done = cur_valid_reg && pop;
    // Load the next burst once the current one has gone out.
    assign q_pop     = !q_empty && (!cur_valid_reg || (beat_done && final_beat));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (beat_done)
        begin
            if (final_beat)
            begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_cmd;
    end

endmodule

/* design/stream_find_replace_top.sv */
// Streaming find-and-replace over a byte stream.
// Input queue side: drive in_byte/in_last with push; a transaction happens on a
// clock edge with push high and full low. One byte can be taken every cycle
// while full is low. Output queue side: while empty is low the oldest result is
// on out_byte, out_byte_valid, out_last and match_total; pop takes it. Results
// leave at one per cycle while pop is high; N replacement or flushed bytes give
// N results; a match with an empty replacement gives none, or, if it ends the
// string, one with out_byte_valid low. Each result is queued, then registered.
// A front stage compares the window and queues bursts into a four-entry command
// queue; the back stage serializes them. full rises when the queue fills, either
// because pop is held low or because bursts arrive faster than one byte a cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while the block is idle.
// Reset (rst_n low, asynchronous) empties the queue, clears the pending window
// and match count, and restores find length 1, replace length 0, zero patterns.
module stream_find_replace_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  sfr_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              out_byte_valid,
    output logic              out_last,
    output logic [15:0]       match_total
);
    import sfr_pkg::*;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic front_push;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    sfr_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (q_pop),
        .rd_cmd (q_cmd),
        .empty  (q_empty)
    );

    sfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_cmd          (q_cmd),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .out_last       (out_last),
        .match_total    (match_total)
    );

endmodule
